// ===== hdl/gai_pkg.sv =====
// Shared types, constants and small tables for the gyro attitude integrator.
// Used by gyro_attitude_integrator_top; depends on nothing else.
`timescale 1ns / 1ps

package gai_pkg;

  // Number of CORDIC rotations for cos/sin of the half angle (12..32).
  localparam int CORDIC_STEPS = 24;
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic [37:0] TWO_PI_U38 = 38'd6746518852;
  localparam logic signed [34:0] CORDIC_GAIN_Q30 = 35'sd652032874;

  localparam logic [31:0] STEP_TIME_RST = 32'd4294967;
  localparam logic [30:0] STILL_LIMIT_RST = 31'd1;

  // Register index, taken from address bit 2.
  localparam logic REG_STEP_TIME = 1'b0;
  localparam logic REG_STILL_LIMIT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ, ST_SQ_ACC, ST_SPD_SQRT, ST_STILL,
    ST_ANG, ST_ANG_ACC, ST_MOD, ST_FOLD, ST_CORDIC, ST_TURN,
    ST_AX_MUL, ST_AX_LD, ST_AX_DIV, ST_AX_FIN,
    ST_QM, ST_QM_ACC,
    ST_NABS, ST_NSHIFT, ST_NSQ, ST_NSQ_ACC, ST_LEN_SQRT, ST_LEN_CHK,
    ST_ND_LD, ST_ND_DIV, ST_ND_FIN,
    ST_OUT
  } state_t;

  // atan(2^-i) in Q2.30, rounded to nearest.
  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] r;
    case (i)
      5'd0: r = 35'sd843314857;
      5'd1: r = 35'sd497837829;
      5'd2: r = 35'sd263043837;
      5'd3: r = 35'sd133525159;
      5'd4: r = 35'sd67021687;
      5'd5: r = 35'sd33543516;
      5'd6: r = 35'sd16775851;
      5'd7: r = 35'sd8388437;
      5'd8: r = 35'sd4194283;
      5'd9: r = 35'sd2097149;
      5'd10: r = 35'sd1048576;
      5'd11: r = 35'sd524288;
      5'd12: r = 35'sd262144;
      5'd13: r = 35'sd131072;
      5'd14: r = 35'sd65536;
      5'd15: r = 35'sd32768;
      5'd16: r = 35'sd16384;
      5'd17: r = 35'sd8192;
      5'd18: r = 35'sd4096;
      5'd19: r = 35'sd2048;
      5'd20: r = 35'sd1024;
      5'd21: r = 35'sd512;
      5'd22: r = 35'sd256;
      5'd23: r = 35'sd128;
      5'd24: r = 35'sd64;
      5'd25: r = 35'sd32;
      5'd26: r = 35'sd16;
      5'd27: r = 35'sd8;
      5'd28: r = 35'sd4;
      5'd29: r = 35'sd2;
      5'd30: r = 35'sd1;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

  // Sign of term j in component k of attitude * turn ({k, j} packed).
  function automatic logic qm_neg(input logic [3:0] kj);
    logic r;
    case (kj)
      4'd1, 4'd2, 4'd3, 4'd7, 4'd9, 4'd14: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

endpackage

// ===== hdl/gyro_attitude_integrator_top.sv =====
// Gyro attitude integrator: keeps a Q2.30 attitude quaternion and turns it by
// body-rate samples. Depends on gai_pkg (states, constants, atan table).
`timescale 1ns / 1ps

// Usage
//   in_*  : one word per item. in_tuser is the kind (0 gyro sample, 1 load
//           attitude). in_tdata carries the rates and the load quaternion.
//   out_* : one word per item, the new normalized attitude, with a still flag
//           in out_tuser (set when a sample was at or below still_limit).
//   cfg_* : APB-style port, step_time at address 0, still_limit at address 4.
//           Write only while the block is idle.
// Timing
//   A word is taken only in idle; the block then runs a sequencer around one
//   shared 33x33 multiplier, a one-bit-per-cycle square root and a
//   one-bit-per-cycle divider. A load runs one 32-step root and four 32-step
//   divisions for normalization, a still sample adds the speed root, and a
//   turning sample adds three more 32-step divisions for the turn axis, the
//   angle reduction, the quaternion product and CORDIC_STEPS CORDIC
//   rotations. The result sits in an output register; the next word is
//   accepted while it waits. If the receiver stalls and the next result is
//   done, hold in the final state until the output register frees.
// Reset
//   Synchronous, active low: attitude returns to identity, registers to their
//   defaults, the output register empties.
module gyro_attitude_integrator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z (32 bits each)
  input  logic [223:0] in_tdata,
  // kind
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // att_w, att_x, att_y, att_z (32 bits each)
  output logic [127:0] out_tdata,
  // was_still
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  gai_pkg::state_t state_r, state_nxt;

  // Configuration and attitude state
  logic [31:0]        step_r;
  logic [30:0]        limit_r;
  logic signed [31:0] att_r [4];

  // Item and working registers
  logic signed [31:0] rate_r [3];
  logic               still_r;
  logic [3:0]         idx_r;
  logic [4:0]         dcnt_r;
  logic [63:0]        acc_r;
  logic signed [65:0] mul_p_r;
  logic [63:0]        rad_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r;     // speed after the first root, length after the second
  logic [37:0]        ang_r;
  logic signed [34:0] z_r, cx_r, cy_r;
  logic               neg_r;
  logic signed [32:0] s_r;
  logic signed [32:0] turn_r [4];
  logic               nneg_r;
  logic [31:0]        drem_r, lo_r;
  logic signed [35:0] v_r [4];
  logic [35:0]        m_r [4];
  logic               sgn_r [4];
  logic signed [31:0] res_r [4];

  logic [127:0]       out_data_r;
  logic               out_still_r, out_valid_r;

  // Shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  // Step logic of the shared units
  logic [35:0] sq_t, sq_trial;
  logic [32:0] dv_t, dv_den;
  logic        big;
  logic [63:0] ang_sum;
  logic signed [34:0] fold_t;
  logic signed [35:0] qm_term;
  logic [63:0] ax_mag;
  logic        load_out;

  assign in_tready  = (state_r == gai_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_still_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == gai_pkg::REG_STILL_LIMIT) ? {1'b0, limit_r} : step_r;

  assign load_out = (state_r == gai_pkg::ST_OUT) && (!out_valid_r || out_tready);

  // Select multiplier operands by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      gai_pkg::ST_SQ: begin
        mul_a = $signed({1'b0, gai_pkg::mag32(rate_r[idx_r[1:0]])});
        mul_b = mul_a;
      end
      gai_pkg::ST_ANG: begin
        mul_a = $signed({1'b0, root_r});
        mul_b = (idx_r == 4'd0) ? $signed({9'b0, step_r[31:8]}) : $signed({25'b0, step_r[7:0]});
      end
      gai_pkg::ST_AX_MUL: begin
        mul_a = 33'(rate_r[idx_r[1:0]]);
        mul_b = s_r;
      end
      gai_pkg::ST_QM: begin
        mul_a = 33'(att_r[idx_r[1:0]]);
        mul_b = turn_r[idx_r[3:2] ^ idx_r[1:0]];
      end
      gai_pkg::ST_NSQ: begin
        mul_a = $signed({2'b0, m_r[idx_r[1:0]][30:0]});
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Root, divider and misc combinational steps
  always_comb begin
    sq_t     = {rem_r, rad_r[63:62]};
    sq_trial = {2'b0, root_r, 2'b01};
    dv_den   = {1'b0, root_r};
    dv_t     = {drem_r, lo_r[31]};
    big      = (m_r[0][35:31] != '0) || (m_r[1][35:31] != '0) ||
               (m_r[2][35:31] != '0) || (m_r[3][35:31] != '0);
    ang_sum  = acc_r + {32'b0, mul_p_r[39:8]};
    fold_t   = $signed({2'b0, ang_r[32:0]});
    if (fold_t > gai_pkg::PI_Q30) begin
      fold_t = fold_t - gai_pkg::TWO_PI_Q30;
    end
    qm_term  = mul_p_r[65:30];
    ax_mag   = gai_pkg::mag64(mul_p_r[63:0]);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gai_pkg::ST_IDLE:
        if (in_tvalid) begin
          state_nxt = in_tuser ? gai_pkg::ST_NABS : gai_pkg::ST_SQ;
        end
      gai_pkg::ST_SQ:      state_nxt = gai_pkg::ST_SQ_ACC;
      gai_pkg::ST_SQ_ACC:
        state_nxt = (idx_r == 4'd2) ? gai_pkg::ST_SPD_SQRT : gai_pkg::ST_SQ;
      gai_pkg::ST_SPD_SQRT:
        if (dcnt_r == 5'd31) begin
          state_nxt = gai_pkg::ST_STILL;
        end
      gai_pkg::ST_STILL:
        state_nxt = (root_r <= {1'b0, limit_r}) ? gai_pkg::ST_NABS : gai_pkg::ST_ANG;
      gai_pkg::ST_ANG:     state_nxt = gai_pkg::ST_ANG_ACC;
      gai_pkg::ST_ANG_ACC:
        state_nxt = (idx_r == 4'd0) ? gai_pkg::ST_ANG : gai_pkg::ST_MOD;
      gai_pkg::ST_MOD:
        if (dcnt_r == 5'd0) begin
          state_nxt = gai_pkg::ST_FOLD;
        end
      gai_pkg::ST_FOLD:    state_nxt = gai_pkg::ST_CORDIC;
      gai_pkg::ST_CORDIC:
        if (dcnt_r == gai_pkg::CORDIC_LAST) begin
          state_nxt = gai_pkg::ST_TURN;
        end
      gai_pkg::ST_TURN:    state_nxt = gai_pkg::ST_AX_MUL;
      gai_pkg::ST_AX_MUL:  state_nxt = gai_pkg::ST_AX_LD;
      gai_pkg::ST_AX_LD:   state_nxt = gai_pkg::ST_AX_DIV;
      gai_pkg::ST_AX_DIV:
        if (dcnt_r == 5'd31) begin
          state_nxt = gai_pkg::ST_AX_FIN;
        end
      gai_pkg::ST_AX_FIN:
        state_nxt = (idx_r[1:0] == 2'd2) ? gai_pkg::ST_QM : gai_pkg::ST_AX_MUL;
      gai_pkg::ST_QM:      state_nxt = gai_pkg::ST_QM_ACC;
      gai_pkg::ST_QM_ACC:
        state_nxt = (idx_r == 4'd15) ? gai_pkg::ST_NABS : gai_pkg::ST_QM;
      gai_pkg::ST_NABS:    state_nxt = gai_pkg::ST_NSHIFT;
      gai_pkg::ST_NSHIFT:
        if (!big) begin
          state_nxt = gai_pkg::ST_NSQ;
        end
      gai_pkg::ST_NSQ:     state_nxt = gai_pkg::ST_NSQ_ACC;
      gai_pkg::ST_NSQ_ACC:
        state_nxt = (idx_r == 4'd3) ? gai_pkg::ST_LEN_SQRT : gai_pkg::ST_NSQ;
      gai_pkg::ST_LEN_SQRT:
        if (dcnt_r == 5'd31) begin
          state_nxt = gai_pkg::ST_LEN_CHK;
        end
      gai_pkg::ST_LEN_CHK:
        state_nxt = (root_r == '0) ? gai_pkg::ST_OUT : gai_pkg::ST_ND_LD;
      gai_pkg::ST_ND_LD:   state_nxt = gai_pkg::ST_ND_DIV;
      gai_pkg::ST_ND_DIV:
        if (dcnt_r == 5'd31) begin
          state_nxt = gai_pkg::ST_ND_FIN;
        end
      gai_pkg::ST_ND_FIN:
        state_nxt = (idx_r == 4'd3) ? gai_pkg::ST_OUT : gai_pkg::ST_ND_LD;
      gai_pkg::ST_OUT:
        if (load_out) begin
          state_nxt = gai_pkg::ST_IDLE;
        end
      default: state_nxt = gai_pkg::ST_IDLE;
    endcase
  end

  // Control state, configuration and attitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gai_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= gai_pkg::STEP_TIME_RST;
      limit_r     <= gai_pkg::STILL_LIMIT_RST;
      att_r[0]    <= gai_pkg::ONE_Q30;
      att_r[1]    <= '0;
      att_r[2]    <= '0;
      att_r[3]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 4; i++) begin
          att_r[i] <= res_r[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == gai_pkg::REG_STILL_LIMIT) begin
          limit_r <= cfg_pwdata[30:0];
        end else begin
          step_r <= cfg_pwdata;
        end
      end
    end
  end

  // Datapath: one shared multiplier plus the step units, advanced per state
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (load_out) begin
      out_data_r  <= {res_r[3], res_r[2], res_r[1], res_r[0]};
      out_still_r <= still_r;
    end
    unique case (state_r)
      gai_pkg::ST_IDLE:
        if (in_tvalid) begin
          rate_r[0] <= in_tdata[31:0];
          rate_r[1] <= in_tdata[63:32];
          rate_r[2] <= in_tdata[95:64];
          for (int i = 0; i < 4; i++) begin
            v_r[i] <= 36'($signed(in_tdata[96 + 32*i +: 32]));
          end
          still_r <= 1'b0;
          idx_r   <= '0;
          acc_r   <= '0;
        end
      gai_pkg::ST_SQ_ACC, gai_pkg::ST_NSQ_ACC: begin
        // Last square feeds the root directly
        if ((state_r == gai_pkg::ST_SQ_ACC && idx_r == 4'd2) ||
            (state_r == gai_pkg::ST_NSQ_ACC && idx_r == 4'd3)) begin
          rad_r  <= acc_r + mul_p_r[63:0];
          rem_r  <= '0;
          root_r <= '0;
          dcnt_r <= '0;
        end else begin
          acc_r <= acc_r + mul_p_r[63:0];
        end
        idx_r <= idx_r + 4'd1;
      end
      gai_pkg::ST_SPD_SQRT, gai_pkg::ST_LEN_SQRT: begin
        if (sq_t >= sq_trial) begin
          rem_r  <= 34'(sq_t - sq_trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= sq_t[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
        rad_r  <= {rad_r[61:0], 2'b00};
        dcnt_r <= dcnt_r + 5'd1;
      end
      gai_pkg::ST_STILL: begin
        idx_r <= '0;
        if (root_r <= {1'b0, limit_r}) begin
          still_r <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            v_r[i] <= 36'(att_r[i]);
          end
        end
      end
      gai_pkg::ST_ANG_ACC:
        if (idx_r == 4'd0) begin
          acc_r <= mul_p_r[63:0];
          idx_r <= 4'd1;
        end else begin
          ang_r  <= ang_sum[56:19];
          dcnt_r <= 5'd5;
        end
      gai_pkg::ST_MOD: begin
        // Reduce modulo two pi by shifted subtracts
        if (ang_r >= (gai_pkg::TWO_PI_U38 << dcnt_r[2:0])) begin
          ang_r <= ang_r - (gai_pkg::TWO_PI_U38 << dcnt_r[2:0]);
        end
        dcnt_r <= dcnt_r - 5'd1;
      end
      gai_pkg::ST_FOLD: begin
        if (fold_t > gai_pkg::HALF_PI_Q30) begin
          z_r   <= fold_t - gai_pkg::PI_Q30;
          neg_r <= 1'b1;
        end else if (fold_t < -gai_pkg::HALF_PI_Q30) begin
          z_r   <= fold_t + gai_pkg::PI_Q30;
          neg_r <= 1'b1;
        end else begin
          z_r   <= fold_t;
          neg_r <= 1'b0;
        end
        cx_r   <= gai_pkg::CORDIC_GAIN_Q30;
        cy_r   <= '0;
        dcnt_r <= '0;
      end
      gai_pkg::ST_CORDIC: begin
        if (!z_r[34]) begin
          cx_r <= cx_r - (cy_r >>> dcnt_r);
          cy_r <= cy_r + (cx_r >>> dcnt_r);
          z_r  <= z_r - gai_pkg::atan_q30(dcnt_r);
        end else begin
          cx_r <= cx_r + (cy_r >>> dcnt_r);
          cy_r <= cy_r - (cx_r >>> dcnt_r);
          z_r  <= z_r + gai_pkg::atan_q30(dcnt_r);
        end
        dcnt_r <= dcnt_r + 5'd1;
      end
      gai_pkg::ST_TURN: begin
        turn_r[0] <= neg_r ? 33'(-cx_r) : 33'(cx_r);
        s_r       <= neg_r ? 33'(-cy_r) : 33'(cy_r);
        idx_r     <= '0;
      end
      gai_pkg::ST_AX_LD: begin
        nneg_r <= mul_p_r[63];
        drem_r <= ax_mag[63:32];
        lo_r   <= ax_mag[31:0];
        dcnt_r <= '0;
      end
      gai_pkg::ST_AX_DIV, gai_pkg::ST_ND_DIV: begin
        if (dv_t >= dv_den) begin
          drem_r <= 32'(dv_t - dv_den);
          lo_r   <= {lo_r[30:0], 1'b1};
        end else begin
          drem_r <= dv_t[31:0];
          lo_r   <= {lo_r[30:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 5'd1;
      end
      gai_pkg::ST_AX_FIN: begin
        turn_r[2'(idx_r[1:0] + 2'd1)] <= nneg_r ? -$signed({1'b0, lo_r}) : $signed({1'b0, lo_r});
        idx_r <= (idx_r[1:0] == 2'd2) ? 4'd0 : idx_r + 4'd1;
      end
      gai_pkg::ST_QM_ACC: begin
        if (idx_r[1:0] == 2'd0) begin
          v_r[idx_r[3:2]] <= gai_pkg::qm_neg(idx_r) ? -qm_term : qm_term;
        end else begin
          v_r[idx_r[3:2]] <= gai_pkg::qm_neg(idx_r) ? v_r[idx_r[3:2]] - qm_term
                                                    : v_r[idx_r[3:2]] + qm_term;
        end
        idx_r <= idx_r + 4'd1;
      end
      gai_pkg::ST_NABS:
        for (int i = 0; i < 4; i++) begin
          m_r[i]   <= gai_pkg::mag36(v_r[i]);
          sgn_r[i] <= v_r[i][35];
        end
      gai_pkg::ST_NSHIFT: begin
        // Halve all magnitudes until each fits 31 bits
        if (big) begin
          for (int i = 0; i < 4; i++) begin
            m_r[i] <= m_r[i] >> 1;
          end
        end
        idx_r <= '0;
        acc_r <= '0;
      end
      gai_pkg::ST_LEN_CHK: begin
        if (root_r == '0) begin
          res_r[0] <= gai_pkg::ONE_Q30;
          res_r[1] <= '0;
          res_r[2] <= '0;
          res_r[3] <= '0;
        end
        idx_r <= '0;
      end
      gai_pkg::ST_ND_LD: begin
        drem_r <= {3'b0, m_r[idx_r[1:0]][30:2]};
        lo_r   <= {m_r[idx_r[1:0]][1:0], 30'b0};
        dcnt_r <= '0;
      end
      gai_pkg::ST_ND_FIN: begin
        res_r[idx_r[1:0]] <= sgn_r[idx_r[1:0]] ? -$signed(lo_r) : $signed(lo_r);
        idx_r <= idx_r + 4'd1;
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  // Assertion: a taken word closes the input; it opens again once the result is in the output register
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gai_pkg::ST_ND_DIV |-> root_r != '0)
    else $error("normalize divide by zero length");

  a_speed_above_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gai_pkg::ST_AX_DIV |-> root_r > {1'b0, limit_r})
    else $error("axis divide with still speed");

  a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata == {res_r[3], res_r[2], res_r[1], res_r[0]})
    else $error("output word differs from result");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gai_pkg::ST_OUT |->
      res_r[0] <= gai_pkg::ONE_Q30 && res_r[0] >= -gai_pkg::ONE_Q30 &&
      res_r[1] <= gai_pkg::ONE_Q30 && res_r[1] >= -gai_pkg::ONE_Q30 &&
      res_r[2] <= gai_pkg::ONE_Q30 && res_r[2] >= -gai_pkg::ONE_Q30 &&
      res_r[3] <= gai_pkg::ONE_Q30 && res_r[3] >= -gai_pkg::ONE_Q30)
    else $error("normalized component out of range");

endmodule
